### rtl/pvs_pkg.sv
package pvs_pkg;

	// Sizes of the vertex store
	localparam int MAX_VERTICES = 1024;
	localparam int COORD_BITS   = 16;
	localparam int IDX_W        = $clog2(MAX_VERTICES);
	localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
	localparam int DIFF_W       = COORD_BITS + 1;
	localparam int PROD_W       = 2 * DIFF_W;

	// Request codes on s_axis_tuser; the top three are no-ops
	typedef enum logic [2:0] {
		REQ_PUSH   = 3'd0,
		REQ_POP    = 3'd1,
		REQ_SET    = 3'd2,
		REQ_POINT  = 3'd3,
		REQ_HANDLE = 3'd4,
		REQ_RSV5   = 3'd5,
		REQ_RSV6   = 3'd6,
		REQ_RSV7   = 3'd7
	} req_t;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [DIFF_W-1:0]     diff_t;
	typedef logic signed [PROD_W-1:0]     prod_t;

	// One stored vertex, x in the low half
	typedef struct packed {
		coord_t y;
		coord_t x;
	} vtx_t;

	// One edge handed to the crossing unit: vertex i and its predecessor j
	typedef struct packed {
		logic   vld;
		coord_t xi;
		coord_t yi;
		coord_t xj;
		coord_t yj;
	} edge_req_t;

	// Crossing unit status
	typedef struct packed {
		logic busy;
		logic in_poly;
	} edge_sts_t;

	function automatic diff_t ext(input coord_t v);
		ext = diff_t'(v);
	endfunction

endpackage

### rtl/pvs_vertex_ram.sv
module pvs_vertex_ram (
	input  logic                   clk,
	input  logic                   we,
	input  logic [pvs_pkg::IDX_W-1:0] waddr,
	input  pvs_pkg::vtx_t          wdata,
	input  logic                   re,
	input  logic [pvs_pkg::IDX_W-1:0] raddr,
	output pvs_pkg::vtx_t          rdata
);
	import pvs_pkg::*;

	vtx_t mem [MAX_VERTICES];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/pvs_edge_unit.sv
module pvs_edge_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                clr,
	input  pvs_pkg::coord_t     px,
	input  pvs_pkg::coord_t     py,
	input  pvs_pkg::edge_req_t  req,
	output pvs_pkg::edge_sts_t  sts
);
	import pvs_pkg::*;

	logic  v_s1, v_s2;
	logic  in_range_s1, in_range_s2;
	logic  dpos_s1, dpos_s2;
	diff_t dy_s1, dxp_s1, dpy_s1, d_s1;
	prod_t lhs_s2, rhs_s2;
	logic  tot_q, above_q;
	logic  in_range, up;

	// x strictly between the edge's end points
	always_comb begin
		if (req.xi < req.xj) begin
			in_range = (req.xi < px) && (req.xj > px);
		end else begin
			in_range = (req.xj < px) && (req.xi > px);
		end
	end

	// stage 1: differences
	always_ff @(posedge clk) begin
		in_range_s1 <= in_range;
		dpos_s1     <= req.xi > req.xj;
		dy_s1       <= ext(req.yi) - ext(req.yj);
		dxp_s1      <= ext(px) - ext(req.xj);
		dpy_s1      <= ext(py) - ext(req.yj);
		d_s1        <= ext(req.xi) - ext(req.xj);
	end

	// stage 2: cross products
	always_ff @(posedge clk) begin
		in_range_s2 <= in_range_s1;
		dpos_s2     <= dpos_s1;
		lhs_s2      <= dy_s1 * dxp_s1;
		rhs_s2      <= dpy_s1 * d_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= req.vld;
			v_s2 <= v_s1;
		end
	end

	// edge y above the point, sign of dx folded in
	assign up = dpos_s2 ? (lhs_s2 > rhs_s2) : (lhs_s2 < rhs_s2);

	// parity of total and above crossings
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tot_q   <= 1'b0;
			above_q <= 1'b0;
		end else if (clr) begin
			tot_q   <= 1'b0;
			above_q <= 1'b0;
		end else if (v_s2 && in_range_s2) begin
			tot_q   <= ~tot_q;
			above_q <= above_q ^ up;
		end
	end

	assign sts.busy    = v_s1 | v_s2;
	assign sts.in_poly = tot_q | above_q;

endmodule

### rtl/polygon_vertex_store_point_test.sv
// Polygon vertex store with point-in-polygon and handle hit tests. Items come in one
// at a time on the slave stream and each gives exactly one result beat. Push, pop and
// set go straight to the result; a handle test first reads its vertex. A point test walks
// every stored edge through the single read port of the vertex memory, one vertex per
// cycle. The next item is accepted as soon as the previous one has moved to the output
// register, even if that result beat is still stalled. handle_size may only be written
// while no item is in flight.
module polygon_vertex_store_point_test (
	input  logic        clk,
	input  logic        arst_n,
	// config
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,       // handle_size
	// request stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,    // x_coord[15:0], y_coord[31:16], vertex_index[41:32]
	input  logic [2:0]  s_axis_tuser,    // req_type[2:0]
	// result stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata    // inside_res[0], on_handle[1], vertex_count[12:2]
);
	import pvs_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_HREAD = 5'b00010,
		ST_WALK  = 5'b00100,
		ST_DRAIN = 5'b01000,
		ST_DONE  = 5'b10000
	} state_t;

	state_t           state_q;
	logic [7:0]       hsize_q;
	logic [CNT_W-1:0] count_q;
	logic [IDX_W-1:0] walk_q;
	coord_t           px_q, py_q;
	coord_t           prev_x_q, prev_y_q;
	logic             rd_vld_s1, first_s1;
	logic             res_inside_q, res_hit_q;
	logic             m_valid_q;
	logic [15:0]      m_data_q;

	logic             accept, out_free;
	req_t             in_req;
	coord_t           in_x, in_y;
	logic [IDX_W-1:0] in_idx;
	logic             full, empty, idx_in_cnt, idx_in_mem;
	logic [CNT_W-1:0] last_idx;

	logic             ram_we, ram_re;
	logic [IDX_W-1:0] ram_waddr, ram_raddr;
	vtx_t             ram_wdata, ram_rdata;
	logic             walk_issue, start_walk;
	edge_req_t        edge_req;
	edge_sts_t        edge_sts;

	logic [6:0]       del;
	diff_t            hdx, hdy, hdel;
	logic             hit;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign out_free      = !m_valid_q || m_axis_tready;

	// unpack the request beat
	assign in_req = req_t'(s_axis_tuser);
	assign in_x   = coord_t'(s_axis_tdata[COORD_BITS-1:0]);
	assign in_y   = coord_t'(s_axis_tdata[16 +: COORD_BITS]);
	assign in_idx = s_axis_tdata[32 +: IDX_W];

	assign full       = (count_q >= CNT_W'(MAX_VERTICES));
	assign empty      = (count_q == '0);
	assign idx_in_cnt = ({1'b0, in_idx} < count_q);
	assign idx_in_mem = ({1'b0, in_idx} < CNT_W'(MAX_VERTICES));
	assign last_idx   = count_q - CNT_W'(1);
	assign start_walk = accept && (in_req == REQ_POINT) && !empty;
	assign walk_issue = (state_q == ST_WALK);

	// memory write: push at the top, set at an index
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = in_idx;
		ram_wdata = '{y: in_y, x: in_x};
		if (accept && in_req == REQ_PUSH && !full) begin
			ram_we    = 1'b1;
			ram_waddr = count_q[IDX_W-1:0];
		end else if (accept && in_req == REQ_SET && idx_in_mem) begin
			ram_we    = 1'b1;
		end
	end

	// memory read: last vertex to open a walk, then 0..N-1; handle vertex
	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = walk_q;
		if (start_walk) begin
			ram_re    = 1'b1;
			ram_raddr = last_idx[IDX_W-1:0];
		end else if (accept && in_req == REQ_HANDLE && idx_in_cnt) begin
			ram_re    = 1'b1;
			ram_raddr = in_idx;
		end else if (walk_issue) begin
			ram_re    = 1'b1;
		end
	end

	pvs_vertex_ram u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// walk read tracking, previous vertex holds edge start
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
			first_s1  <= 1'b0;
		end else begin
			rd_vld_s1 <= start_walk || walk_issue;
			first_s1  <= start_walk;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_vld_s1) begin
			prev_x_q <= ram_rdata.x;
			prev_y_q <= ram_rdata.y;
		end
	end

	assign edge_req.vld = rd_vld_s1 && !first_s1;
	assign edge_req.xi  = ram_rdata.x;
	assign edge_req.yi  = ram_rdata.y;
	assign edge_req.xj  = prev_x_q;
	assign edge_req.yj  = prev_y_q;

	pvs_edge_unit u_edge (
		.clk    (clk),
		.arst_n (arst_n),
		.clr    (start_walk),
		.px     (px_q),
		.py     (py_q),
		.req    (edge_req),
		.sts    (edge_sts)
	);

	// handle square: |dx| and |dy| within (size-1)/2
	assign del  = (hsize_q == 8'd0) ? 7'd0 : 7'((hsize_q - 8'd1) >> 1);
	assign hdel = diff_t'({1'b0, del});
	assign hdx  = ext(px_q) - ext(ram_rdata.x);
	assign hdy  = ext(py_q) - ext(ram_rdata.y);
	assign hit  = (hdx >= -hdel) && (hdx <= hdel) && (hdy >= -hdel) && (hdy <= hdel);

	// tested point
	always_ff @(posedge clk) begin
		if (accept) begin
			px_q <= in_x;
			py_q <= in_y;
		end
	end

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hsize_q <= 8'd7;
		end else if (cfg_we) begin
			hsize_q <= cfg_wdata;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			count_q      <= '0;
			walk_q       <= '0;
			res_inside_q <= 1'b0;
			res_hit_q    <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						res_inside_q <= 1'b0;
						res_hit_q    <= 1'b0;
						walk_q       <= '0;
						state_q      <= ST_DONE;
						case (in_req)
							REQ_PUSH: begin
								if (!full) count_q <= count_q + CNT_W'(1);
							end
							REQ_POP: begin
								if (!empty) count_q <= count_q - CNT_W'(1);
							end
							REQ_POINT: begin
								if (!empty) state_q <= ST_WALK;
							end
							REQ_HANDLE: begin
								if (idx_in_cnt) state_q <= ST_HREAD;
							end
							default: begin
							end
						endcase
					end
				end
				ST_HREAD: begin
					res_hit_q <= hit;
					state_q   <= ST_DONE;
				end
				ST_WALK: begin
					walk_q <= walk_q + IDX_W'(1);
					if ({1'b0, walk_q} == last_idx) state_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					if (!rd_vld_s1 && !edge_sts.busy) begin
						res_inside_q <= edge_sts.in_poly;
						state_q      <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			m_data_q <= {3'b000, count_q, res_hit_q, res_inside_q};
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

endmodule

### rtl/pvs_checker.sv
module pvs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [15:0] m_axis_tdata
);
	import pvs_pkg::*;

	// stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result beat changed while stalled");

	// one item in flight: no accept right after an accept
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("request accepted back to back");

	// count never beyond capacity
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[12:2] <= 11'(MAX_VERTICES)))
		else $error("vertex count beyond capacity");

	// a result answers one kind of test only
	a_one_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]))
		else $error("inside and handle flags both set");

endmodule

bind polygon_vertex_store_point_test pvs_checker u_pvs_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

### bench/tb.sv
module tb;
	import pvs_pkg::*;

	// Result beat, packed as on m_axis_tdata (in_poly in bit 0)
	typedef struct packed {
		logic [10:0] count;
		logic        on_handle;
		logic        in_poly;
	} verdict_t;

	// Directed row; want is used only when typed is set
	typedef struct packed {
		req_t       op;
		coord_t     x;
		coord_t     y;
		logic [9:0] idx;
		logic       typed;
		verdict_t   want;
	} dir_row_t;

	localparam int     CYCLE_LIMIT = 800000;
	localparam coord_t CMIN        = 16'sh8000;
	localparam coord_t CMAX        = 16'sh7FFF;
	localparam coord_t CZ          = 16'sh0000;
	localparam coord_t NEAR_MIN    = 16'sh8003;

	// Corner cases first: empty store, one vertex, full-range square, set past count
	localparam dir_row_t DIRECTED [25] = '{
		'{REQ_POP,    CZ,       CZ,       10'd0,    1'b1, '{11'd0, 1'b0, 1'b0}},
		'{REQ_POINT,  CZ,       CZ,       10'd0,    1'b1, '{11'd0, 1'b0, 1'b0}},
		'{REQ_HANDLE, CZ,       CZ,       10'd0,    1'b1, '{11'd0, 1'b0, 1'b0}},
		'{REQ_RSV5,   CMAX,     CMAX,     10'd1023, 1'b1, '{11'd0, 1'b0, 1'b0}},
		'{REQ_PUSH,   CMIN,     CMIN,     10'd0,    1'b1, '{11'd1, 1'b0, 1'b0}},
		'{REQ_POINT,  CZ,       CZ,       10'd0,    1'b1, '{11'd1, 1'b0, 1'b0}},
		'{REQ_HANDLE, NEAR_MIN, NEAR_MIN, 10'd0,    1'b1, '{11'd1, 1'b1, 1'b0}},
		'{REQ_HANDLE, CMIN,     CMIN,     10'd1,    1'b1, '{11'd1, 1'b0, 1'b0}},
		'{REQ_PUSH,   CMAX,     CMIN,     10'd0,    1'b1, '{11'd2, 1'b0, 1'b0}},
		'{REQ_POINT,  CZ,       CZ,       10'd0,    1'b0, '0},
		'{REQ_PUSH,   CMAX,     CMAX,     10'd0,    1'b1, '{11'd3, 1'b0, 1'b0}},
		'{REQ_PUSH,   CMIN,     CMAX,     10'd0,    1'b1, '{11'd4, 1'b0, 1'b0}},
		'{REQ_POINT,  CZ,       CZ,       10'd0,    1'b0, '0},
		'{REQ_POINT,  CMAX,     CZ,       10'd0,    1'b0, '0},
		'{REQ_POINT,  CMIN,     CMIN,     10'd0,    1'b0, '0},
		'{REQ_POINT,  CZ,       CMAX,     10'd0,    1'b0, '0},
		'{REQ_SET,    CMAX,     CMAX,     10'd1023, 1'b1, '{11'd4, 1'b0, 1'b0}},
		'{REQ_SET,    CZ,       CZ,       10'd2,    1'b1, '{11'd4, 1'b0, 1'b0}},
		'{REQ_POINT,  16'sd1,   16'sd1,   10'd0,    1'b0, '0},
		'{REQ_HANDLE, CMIN,     CMAX,     10'd3,    1'b1, '{11'd4, 1'b1, 1'b0}},
		'{REQ_POP,    CZ,       CZ,       10'd0,    1'b1, '{11'd3, 1'b0, 1'b0}},
		'{REQ_RSV6,   CMIN,     CMAX,     10'd512,  1'b1, '{11'd3, 1'b0, 1'b0}},
		'{REQ_RSV7,   CMAX,     CMIN,     10'd511,  1'b1, '{11'd3, 1'b0, 1'b0}},
		'{REQ_HANDLE, CMIN,     CMAX,     10'd3,    1'b1, '{11'd3, 1'b0, 1'b0}},
		'{REQ_POINT,  -16'sd100, 16'sd100, 10'd0,   1'b0, '0}
	};

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [7:0]  cfg_wdata;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata;    // x_coord[15:0], y_coord[31:16], vertex_index[41:32]
	logic [2:0]  s_axis_tuser;    // req_type[2:0]
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [15:0] m_axis_tdata;    // inside_res[0], on_handle[1], vertex_count[12:2]

	// Shadow of the block's state
	coord_t     shadow_x [MAX_VERTICES];
	coord_t     shadow_y [MAX_VERTICES];
	int         vtx_count;
	logic [7:0] handle_size;

	verdict_t pending_verdicts [$];
	int       mismatches;
	int       cycle_count;
	int       effective_reqs;
	int       n_point, n_inside, n_handle, n_hits, peak_count;
	int       drv_left;
	bit       drv_calm;

	polygon_vertex_store_point_test u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Runaway guard
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: no end after %0d cycles, %0d results outstanding", $time,
				cycle_count, pending_verdicts.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Per-beat wait; runs of busy and calm stretches
	function automatic int draw_gap(inout int left, inout bit calm);
		if (left == 0) begin
			left = $urandom_range(8, 40);
			calm = ($urandom_range(0, 3) == 0);
		end
		left--;
		return calm ? 0 : int'($urandom_range(0, 12));
	endfunction

	function automatic int half_side();
		return (handle_size == 0) ? 0 : (int'(handle_size) - 1) / 2;
	endfunction

	function automatic coord_t clampc(input int v);
		if (v > 32767)
			return CMAX;
		if (v < -32768)
			return CMIN;
		return coord_t'(v);
	endfunction

	function automatic int jitter(input int c, input int s);
		return c + int'($urandom_range(0, 2 * s)) - s;
	endfunction

	// Crossing count over all edges, closing edge included; exact integer compare
	function automatic logic point_in_polygon(input coord_t px, input coord_t py);
		int     above, below, j;
		longint xi, yi, xj, yj, dx, lhs, rhs, lpx, lpy;
		bit     up;
		above = 0;
		below = 0;
		lpx = px;
		lpy = py;
		for (int i = 0; i < vtx_count; i++) begin
			j = (i > 0) ? i - 1 : vtx_count - 1;
			xi = shadow_x[i];
			yi = shadow_y[i];
			xj = shadow_x[j];
			yj = shadow_y[j];
			if ((xi < lpx && xj > lpx) || (xj < lpx && xi > lpx)) begin
				dx = xi - xj;
				lhs = (yi - yj) * (lpx - xj);
				rhs = (lpy - yj) * dx;
				up = (dx > 0) ? (lhs > rhs) : (lhs < rhs);
				if (up)
					above++;
				else
					below++;
			end
		end
		return ((above + below) % 2 == 1) || (above % 2 == 1);
	endfunction

	// Applies one request to the shadow state and returns the result beat
	function automatic verdict_t predict_verdict(input req_t op, input coord_t x,
			input coord_t y, input logic [9:0] idx);
		verdict_t v;
		int       d;
		v = '0;
		case (op)
			REQ_PUSH: begin
				if (vtx_count < MAX_VERTICES) begin
					shadow_x[vtx_count] = x;
					shadow_y[vtx_count] = y;
					vtx_count++;
				end
			end
			REQ_POP: begin
				if (vtx_count > 0)
					vtx_count--;
			end
			REQ_SET: begin
				shadow_x[idx] = x;
				shadow_y[idx] = y;
			end
			REQ_POINT: begin
				v.in_poly = point_in_polygon(x, y);
				n_point++;
				n_inside += v.in_poly;
			end
			REQ_HANDLE: begin
				n_handle++;
				if (int'(idx) < vtx_count) begin
					d = half_side();
					v.on_handle = int'(x) >= int'(shadow_x[idx]) - d &&
						int'(x) <= int'(shadow_x[idx]) + d &&
						int'(y) >= int'(shadow_y[idx]) - d &&
						int'(y) <= int'(shadow_y[idx]) + d;
				end
				n_hits += v.on_handle;
			end
			default: ;
		endcase
		v.count = 11'(vtx_count);
		if (vtx_count > peak_count)
			peak_count = vtx_count;
		return v;
	endfunction

	// Drive one request beat and queue what it should produce
	task automatic issue(input req_t op, input coord_t x, input coord_t y,
			input logic [9:0] idx, input logic typed = 1'b0, input verdict_t want = '0);
		int       gap;
		verdict_t v;
		gap = draw_gap(drv_left, drv_calm);
		@(negedge clk);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tdata  <= {6'd0, idx, y, x};
		s_axis_tuser  <= op;
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		if (!(op >= REQ_RSV5 || (op == REQ_POP && vtx_count == 0) ||
				(op == REQ_PUSH && vtx_count == MAX_VERTICES)))
			effective_reqs++;
		v = predict_verdict(op, x, y, idx);
		if (typed)
			v = want;
		pending_verdicts = {pending_verdicts, v};
	endtask

	// Register write once nothing is in flight
	task automatic set_handle_size(input logic [7:0] val);
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending_verdicts.size() != 0) @(negedge clk);
		cfg_wdata <= val;
		cfg_we    <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
		handle_size = val;
	endtask

	// Result side: random stalls, every beat checked against the oldest expectation
	initial begin
		int       gap, left;
		bit       calm;
		verdict_t got, want;
		m_axis_tready = 1'b0;
		left = 0;
		calm = 1'b0;
		@(posedge arst_n);
		forever begin
			gap = draw_gap(left, calm);
			@(negedge clk);
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			got = verdict_t'(m_axis_tdata[12:0]);
			if (pending_verdicts.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result beat inside=%0d on_handle=%0d count=%0d",
					$time, got.in_poly, got.on_handle, got.count);
			end else begin
				want = pending_verdicts.pop_front();
				if (got !== want) begin
					mismatches++;
					$display("%0t: expected inside=%0d on_handle=%0d count=%0d, got %0d %0d %0d",
						$time, want.in_poly, want.on_handle, want.count,
						got.in_poly, got.on_handle, got.count);
				end
			end
		end
	end

	// Stimulus
	initial begin
		logic [7:0] hs_plan [5];
		int         span, cx, cy, nv, nq, pick, k, r, stop_at;
		int         spans [4];
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_wdata     = 8'd0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = '0;
		vtx_count     = 0;
		handle_size   = 8'd7;
		mismatches    = 0;
		cycle_count   = 0;
		effective_reqs = 0;
		n_point = 0; n_inside = 0; n_handle = 0; n_hits = 0; peak_count = 0;
		drv_left = 0;
		drv_calm = 1'b0;
		spans = '{12, 300, 5000, 40000};
		hs_plan = '{8'd1, 8'd0, 8'd2, 8'd255, 8'($urandom_range(3, 254))};
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		// Directed table, handle size at its reset value
		foreach (DIRECTED[i])
			issue(DIRECTED[i].op, DIRECTED[i].x, DIRECTED[i].y, DIRECTED[i].idx,
				DIRECTED[i].typed, DIRECTED[i].want);

		// Random part: small polygons with queries around them, plus raw noise
		for (int p = 0; p < 5; p++) begin
			set_handle_size(hs_plan[p]);
			stop_at = effective_reqs + 108;
			while (effective_reqs < stop_at) begin
				if ($urandom_range(0, 99) < 85) begin
					if ($urandom_range(0, 9) < 7 || vtx_count > 24)
						while (vtx_count > 0)
							issue(REQ_POP, coord_t'($urandom), coord_t'($urandom),
								10'($urandom));
					span = spans[$urandom_range(0, 3)];
					cx = int'(coord_t'($urandom));
					cy = int'(coord_t'($urandom));
					nv = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2)
						: $urandom_range(3, 10);
					repeat (nv)
						issue(REQ_PUSH, clampc(jitter(cx, span)), clampc(jitter(cy, span)),
							10'($urandom));
					nq = $urandom_range(2, 8);
					repeat (nq) begin
						pick = $urandom_range(0, 99);
						if (pick < 50) begin
							issue(REQ_POINT, clampc(jitter(cx, span + 2)),
								clampc(jitter(cy, span + 2)), 10'($urandom));
						end else if (pick < 75) begin
							// mostly near a live vertex, straddling the handle edge
							if (vtx_count > 0 && $urandom_range(0, 9) != 0) begin
								k = $urandom_range(0, vtx_count - 1);
								r = half_side() + 1;
								issue(REQ_HANDLE, clampc(jitter(shadow_x[k], r)),
									clampc(jitter(shadow_y[k], r)), 10'(k));
							end else begin
								issue(REQ_HANDLE, clampc(jitter(cx, span)),
									clampc(jitter(cy, span)), 10'($urandom));
							end
						end else if (pick < 88) begin
							k = (vtx_count > 0) ? $urandom_range(0, vtx_count - 1) : 0;
							issue(REQ_SET, clampc(jitter(cx, span)), clampc(jitter(cy, span)),
								10'(k));
						end else if (pick < 93) begin
							// write past the count: entry changes, count does not
							issue(REQ_SET, coord_t'($urandom), coord_t'($urandom),
								10'($urandom_range(vtx_count, 1023)));
						end else if (pick < 97) begin
							issue(REQ_PUSH, clampc(jitter(cx, span)), clampc(jitter(cy, span)),
								10'($urandom));
						end else begin
							issue(REQ_POP, CZ, CZ, 10'($urandom));
						end
					end
				end else begin
					issue(req_t'($urandom_range(0, 7)), coord_t'($urandom),
						coord_t'($urandom), 10'($urandom));
				end
			end
		end

		// Drain and let any stray beat show up
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending_verdicts.size() != 0) @(negedge clk);
		repeat (40) @(negedge clk);
		$display("%0d effective requests: %0d point tests (%0d inside), %0d handle tests (%0d hits)",
			effective_reqs, n_point, n_inside, n_handle, n_hits);
		$display("store peaked at %0d vertices, %0d mismatches", peak_count, mismatches);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

### files.f
rtl/pvs_pkg.sv
rtl/pvs_vertex_ram.sv
rtl/pvs_edge_unit.sv
rtl/polygon_vertex_store_point_test.sv
rtl/pvs_checker.sv
bench/tb.sv
